### design/assert_macros.svh
// Assertion helpers shared by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside of reset.
`define VRFE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define VRFE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### design/vrfe_pkg.sv
package vrfe_pkg;

  localparam int unsigned CELL_W    = 4;
  localparam int unsigned OCC_W     = 16;
  localparam int unsigned SLOT_W    = 2 * OCC_W;
  localparam int unsigned SLOT_IDX_W = 5;
  localparam int unsigned COORD_W   = 5;
  localparam int unsigned CORNER_W  = 3 * COORD_W;
  localparam int unsigned CNT_W     = 17;
  localparam int unsigned CODE_W    = 3;
  localparam int unsigned Q_DEPTH   = 2;
  localparam int unsigned Q_PTR_W   = 1;
  localparam int unsigned Q_CNT_W   = 2;
  localparam logic [CNT_W-1:0] VERTS_PER_FACE = CNT_W'(4);

  typedef enum logic [1:0] {
    AXIS_X    = 2'd0,
    AXIS_Y    = 2'd1,
    AXIS_Z    = 2'd2,
    AXIS_NONE = 2'd3
  } axis_e;

  typedef enum logic [CODE_W-1:0] {
    FACE_POS_X = 3'd0,
    FACE_NEG_X = 3'd1,
    FACE_POS_Y = 3'd2,
    FACE_NEG_Y = 3'd3,
    FACE_NEG_Z = 3'd4,
    FACE_POS_Z = 3'd5
  } face_e;

  // One occupancy row.
  typedef struct packed {
    logic              chunk_start;
    logic [1:0]        axis;
    logic [CELL_W-1:0] outer_a;
    logic [CELL_W-1:0] outer_b;
    logic [OCC_W-1:0]  occupancy_bits;
  } row_t;

  // One emitted face.
  typedef struct packed {
    logic [CODE_W-1:0]   face_code;
    logic [CELL_W-1:0]   cell_x;
    logic [CELL_W-1:0]   cell_y;
    logic [CELL_W-1:0]   cell_z;
    logic [CORNER_W-1:0] corner_zero;
    logic [CORNER_W-1:0] corner_one;
    logic [CORNER_W-1:0] corner_two;
    logic [CORNER_W-1:0] corner_three;
    logic [CNT_W-1:0]    base_index;
    logic                last_face;
  } face_t;

  // Classified row: two face slots per cell, in emission order.
  typedef struct packed {
    logic              chunk_start;
    logic [1:0]        axis;
    logic [CELL_W-1:0] outer_a;
    logic [CELL_W-1:0] outer_b;
    logic [SLOT_W-1:0] slots;
  } entry_t;

  // Corner offsets per face code, corner zero in the top bits, each {ox, oy, oz}.
  function automatic logic [11:0] corner_offsets(logic [CODE_W-1:0] code);
    logic [11:0] ofs;
    unique case (code)
      FACE_POS_X: ofs = {3'b111, 3'b101, 3'b110, 3'b100};
      FACE_NEG_X: ofs = {3'b010, 3'b000, 3'b011, 3'b001};
      FACE_POS_Y: ofs = {3'b010, 3'b011, 3'b110, 3'b111};
      FACE_NEG_Y: ofs = {3'b001, 3'b000, 3'b101, 3'b100};
      FACE_NEG_Z: ofs = {3'b110, 3'b100, 3'b010, 3'b000};
      FACE_POS_Z: ofs = {3'b011, 3'b001, 3'b111, 3'b101};
      default:    ofs = '0;
    endcase
    return ofs;
  endfunction

  // Pack one corner as x | y << 5 | z << 10.
  function automatic logic [CORNER_W-1:0] pack_corner(logic [CELL_W-1:0] x,
                                                      logic [CELL_W-1:0] y,
                                                      logic [CELL_W-1:0] z,
                                                      logic [2:0] ofs);
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
    logic [COORD_W-1:0] pz;
    px = {1'b0, x} + COORD_W'(ofs[2]);
    py = {1'b0, y} + COORD_W'(ofs[1]);
    pz = {1'b0, z} + COORD_W'(ofs[0]);
    return {pz, py, px};
  endfunction

endpackage

### design/vrfe_row_if.sv
interface vrfe_row_if;
  logic             valid;
  logic             ready;
  vrfe_pkg::row_t   data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### design/vrfe_face_if.sv
interface vrfe_face_if;
  logic             valid;
  logic             ready;
  vrfe_pkg::face_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### design/vrfe_front.sv
module vrfe_front #(
  parameter int unsigned ROW_CELLS = 16
) (
  vrfe_row_if.sink         row_i,
  output logic             push_o,
  output vrfe_pkg::entry_t entry_o,
  input  logic             full_i
);

  localparam int unsigned EffCells = (ROW_CELLS < vrfe_pkg::OCC_W) ? ROW_CELLS
                                                                   : vrfe_pkg::OCC_W;
  localparam logic [vrfe_pkg::OCC_W-1:0] RowMask =
    vrfe_pkg::OCC_W'((33'd1 << EffCells) - 33'd1);

  logic [vrfe_pkg::OCC_W-1:0] row;
  logic [vrfe_pkg::OCC_W-1:0] next_exp;
  logic [vrfe_pkg::OCC_W-1:0] prev_exp;
  logic [vrfe_pkg::OCC_W-1:0] first_side;
  logic [vrfe_pkg::OCC_W-1:0] second_side;
  logic [vrfe_pkg::SLOT_W-1:0] slots;

  // Find exposed faces on both sides of each solid cell
  assign row      = row_i.data.occupancy_bits & RowMask;
  assign next_exp = row & ~(row >> 1);
  assign prev_exp = row & ~(row << 1);

  // Order the two sides by face code; drop rows on the unused axis
  always_comb begin
    case (row_i.data.axis)
      vrfe_pkg::AXIS_Z: begin
        first_side  = prev_exp;
        second_side = next_exp;
      end
      vrfe_pkg::AXIS_NONE: begin
        first_side  = '0;
        second_side = '0;
      end
      default: begin
        first_side  = next_exp;
        second_side = prev_exp;
      end
    endcase
  end

  // Interleave into slots: slot 2c is the first face of cell c, 2c+1 the second
  always_comb begin
    for (int c = 0; c < vrfe_pkg::OCC_W; c++) begin
      slots[2*c]   = first_side[c];
      slots[2*c+1] = second_side[c];
    end
  end

  assign row_i.ready = !full_i;
  assign push_o      = row_i.valid && !full_i;

  assign entry_o.chunk_start = row_i.data.chunk_start;
  assign entry_o.axis        = row_i.data.axis;
  assign entry_o.outer_a     = row_i.data.outer_a;
  assign entry_o.outer_b     = row_i.data.outer_b;
  assign entry_o.slots       = slots;

endmodule

### design/vrfe_queue.sv
`include "assert_macros.svh"

module vrfe_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  vrfe_pkg::entry_t entry_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output vrfe_pkg::entry_t entry_o
);

  vrfe_pkg::entry_t mem_q [vrfe_pkg::Q_DEPTH];

  logic [vrfe_pkg::Q_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [vrfe_pkg::Q_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [vrfe_pkg::Q_CNT_W-1:0] count_q, count_d;
  logic                         do_push;
  logic                         do_pop;

  assign full_o  = (count_q == vrfe_pkg::Q_CNT_W'(vrfe_pkg::Q_DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign entry_o = mem_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store incoming words
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  `VRFE_ASSERT(q_count_bound, count_q <= vrfe_pkg::Q_CNT_W'(vrfe_pkg::Q_DEPTH),
               "queue occupancy above depth")
  `VRFE_ASSERT(q_ptr_track, (wr_ptr_q - rd_ptr_q) == count_q[vrfe_pkg::Q_PTR_W-1:0],
               "queue pointers disagree with occupancy")

endmodule

### design/vrfe_back.sv
`include "assert_macros.svh"

module vrfe_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             empty_i,
  input  vrfe_pkg::entry_t entry_i,
  output logic             pop_o,
  vrfe_face_if.source      face_o
);

  logic [vrfe_pkg::SLOT_W-1:0]     slots_q, slots_d;
  logic [1:0]                      axis_q;
  logic [vrfe_pkg::CELL_W-1:0]     outer_a_q;
  logic [vrfe_pkg::CELL_W-1:0]     outer_b_q;
  logic [vrfe_pkg::CNT_W-1:0]      counter_q, counter_d;
  logic                            face_valid_q, face_valid_d;
  vrfe_pkg::face_t                 face_q;
  vrfe_pkg::face_t                 face_d;

  logic                            busy;
  logic                            emit;
  logic                            last;
  logic [vrfe_pkg::SLOT_W-1:0]     lowest;
  logic [vrfe_pkg::SLOT_W-1:0]     remain;
  logic [vrfe_pkg::SLOT_IDX_W-1:0] slot_idx;
  logic [vrfe_pkg::CELL_W-1:0]     cell_pos;
  logic [vrfe_pkg::CELL_W-1:0]     fx, fy, fz;
  logic [vrfe_pkg::CODE_W-1:0]     code;
  logic [11:0]                     ofs;

  // Pick the lowest pending face slot
  assign busy   = (slots_q != '0);
  assign lowest = slots_q & (~slots_q + 1'b1);
  assign remain = slots_q & ~lowest;
  assign last   = (remain == '0);

  always_comb begin
    slot_idx = '0;
    for (int i = 0; i < vrfe_pkg::SLOT_W; i++) begin
      slot_idx = slot_idx | (lowest[i] ? vrfe_pkg::SLOT_IDX_W'(i) : '0);
    end
  end

  // Place the cell in the chunk and name the face
  assign cell_pos = slot_idx[vrfe_pkg::SLOT_IDX_W-1:1];

  always_comb begin
    unique case (axis_q)
      vrfe_pkg::AXIS_X: begin
        fx = cell_pos;
        fy = outer_a_q;
        fz = outer_b_q;
      end
      vrfe_pkg::AXIS_Y: begin
        fx = outer_a_q;
        fy = cell_pos;
        fz = outer_b_q;
      end
      default: begin
        fx = outer_a_q;
        fy = outer_b_q;
        fz = cell_pos;
      end
    endcase
  end

  assign code = {axis_q, slot_idx[0]};
  assign ofs  = vrfe_pkg::corner_offsets(code);

  // Build the face word
  always_comb begin
    face_d.face_code    = code;
    face_d.cell_x       = fx;
    face_d.cell_y       = fy;
    face_d.cell_z       = fz;
    face_d.corner_zero  = vrfe_pkg::pack_corner(fx, fy, fz, ofs[11:9]);
    face_d.corner_one   = vrfe_pkg::pack_corner(fx, fy, fz, ofs[8:6]);
    face_d.corner_two   = vrfe_pkg::pack_corner(fx, fy, fz, ofs[5:3]);
    face_d.corner_three = vrfe_pkg::pack_corner(fx, fy, fz, ofs[2:0]);
    face_d.base_index   = counter_q;
    face_d.last_face    = last;
  end

  // Emit when the output register is free; load the next row after the last face
  assign emit  = busy && (!face_valid_q || face_o.ready);
  assign pop_o = !empty_i && (!busy || (emit && last));

  always_comb begin
    slots_d = slots_q;
    if (pop_o) begin
      slots_d = entry_i.slots;
    end else if (emit) begin
      slots_d = remain;
    end
  end

  // Clear on chunk start, which follows any face of the previous row
  always_comb begin
    counter_d = counter_q;
    if (pop_o && entry_i.chunk_start) begin
      counter_d = '0;
    end else if (emit) begin
      counter_d = counter_q + vrfe_pkg::VERTS_PER_FACE;
    end
  end

  always_comb begin
    face_valid_d = face_valid_q;
    if (emit) begin
      face_valid_d = 1'b1;
    end else if (face_o.ready) begin
      face_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_q      <= '0;
      counter_q    <= '0;
      face_valid_q <= 1'b0;
    end else begin
      slots_q      <= slots_d;
      counter_q    <= counter_d;
      face_valid_q <= face_valid_d;
    end
  end

  // Hold row coordinates and the face word
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      axis_q    <= entry_i.axis;
      outer_a_q <= entry_i.outer_a;
      outer_b_q <= entry_i.outer_b;
    end
    if (emit) begin
      face_q <= face_d;
    end
  end

  assign face_o.valid = face_valid_q;
  assign face_o.data  = face_q;

  `VRFE_ASSERT(back_base_aligned, face_valid_q |-> (face_q.base_index[1:0] == 2'b00),
               "base index not a multiple of four")
  `VRFE_ASSERT(back_code_legal,
               face_valid_q |-> (face_q.face_code <= vrfe_pkg::FACE_POS_Z),
               "face code out of range")
  `VRFE_ASSERT(back_one_face_per_emit,
               (emit && !last) |=> ($countones(slots_q) == $past($countones(slots_q)) - 1),
               "scan did not retire exactly one face")
  `VRFE_ASSERT_ALWAYS(back_idle_after_reset, !rst_ni |=> !face_valid_q || !$past(rst_ni) ||
                      $past(emit), "face valid without a face emitted")

endmodule

### design/voxel_row_face_emitter.sv
// Voxel row face emitter.
// Input channel row_i: one occupancy row per word (chunk_start, axis, two outer
// coordinates, one solid bit per cell). Output channel face_o: one word per
// exposed face, with owning cell, face code, four packed corners, base vertex
// index and a last_face flag on the final face of the row.
// A front stage classifies each row into face slots and writes it into a
// two-entry queue; a back stage scans the slots and emits one face per cycle,
// while the receiver does not stall, into an output register.
// Row hand-over: the back stage takes the next row from the queue in the same
// cycle it emits the row's last face; a row holds at most 16 faces.
// Path: an accepted row is written into the queue, then loaded into the
// back-stage slot register, and each face is registered in the output register.
// chunk_start clears the vertex counter before the row's first face; the
// counter advances by four per face and wraps at 2^17.
// Reset clears the queue, the scan and the counter; no face is pending after.
// When the receiver stalls the face word holds, the scan pauses, and rows are
// still accepted until the queue is full.
module voxel_row_face_emitter #(
  parameter int unsigned ROW_CELLS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  vrfe_row_if.sink    row_i,
  vrfe_face_if.source face_o
);

  logic             push;
  logic             full;
  logic             pop;
  logic             empty;
  vrfe_pkg::entry_t entry_in;
  vrfe_pkg::entry_t entry_out;

  vrfe_front #(
    .ROW_CELLS(ROW_CELLS)
  ) u_front (
    .row_i   (row_i),
    .push_o  (push),
    .entry_o (entry_in),
    .full_i  (full)
  );

  vrfe_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry_in),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .entry_o (entry_out)
  );

  vrfe_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .entry_i (entry_out),
    .pop_o   (pop),
    .face_o  (face_o)
  );

endmodule

### sim/face_checker.sv
// Scoreboard for the row face emitter: predict the faces of every accepted
// row word and compare each accepted face word against the oldest one.
module face_checker
  import vrfe_pkg::*;
#(
  parameter int unsigned ROW_CELLS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  vrfe_row_if         row_mon_i,
  vrfe_face_if        face_mon_i,
  output int unsigned mismatch_count_o,
  output int unsigned faces_pending_o,
  output int unsigned faces_checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Running vertex index, kept alongside the block's own counter
  logic [CNT_W-1:0] vertex_count;
  face_t            pending_faces[$];

  initial begin
    mismatch_count_o = 0;
    faces_pending_o  = 0;
    faces_checked_o  = 0;
    vertex_count     = '0;
  end

  // Corner steps {dx, dy, dz} per face, corner zero first
  function automatic logic [0:3][2:0] corner_steps(face_e code);
    case (code)
      FACE_POS_X: return {3'b111, 3'b101, 3'b110, 3'b100};
      FACE_NEG_X: return {3'b010, 3'b000, 3'b011, 3'b001};
      FACE_POS_Y: return {3'b010, 3'b011, 3'b110, 3'b111};
      FACE_NEG_Y: return {3'b001, 3'b000, 3'b101, 3'b100};
      FACE_NEG_Z: return {3'b110, 3'b100, 3'b010, 3'b000};
      default:    return {3'b011, 3'b001, 3'b111, 3'b101};
    endcase
  endfunction

  // Build one face and take four vertices from the running index
  function automatic face_t build_face(face_e code, logic [CELL_W-1:0] x,
                                       logic [CELL_W-1:0] y, logic [CELL_W-1:0] z);
    face_t              f;
    logic [0:3][2:0]    st;
    logic [0:3][14:0]   pc;
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
    logic [COORD_W-1:0] pz;
    st = corner_steps(code);
    for (int n = 0; n < 4; n++) begin
      px = COORD_W'(x) + COORD_W'(st[n][2]);
      py = COORD_W'(y) + COORD_W'(st[n][1]);
      pz = COORD_W'(z) + COORD_W'(st[n][0]);
      pc[n] = {pz, py, px};
    end
    f.face_code    = code;
    f.cell_x       = x;
    f.cell_y       = y;
    f.cell_z       = z;
    f.corner_zero  = pc[0];
    f.corner_one   = pc[1];
    f.corner_two   = pc[2];
    f.corner_three = pc[3];
    f.base_index   = vertex_count;
    f.last_face    = 1'b0;
    vertex_count   = vertex_count + CNT_W'(4);
    return f;
  endfunction

  // Cull one row into its exposed faces, in scan order
  function automatic void cull_row(row_t r);
    face_t             faces[32];
    int                n;
    logic [OCC_W-1:0]  occ;
    logic [OCC_W-1:0]  fwd_open;
    logic [OCC_W-1:0]  back_open;
    logic [CELL_W-1:0] x;
    logic [CELL_W-1:0] y;
    logic [CELL_W-1:0] z;
    logic              lead_on;
    logic              trail_on;
    face_e             lead_code;
    face_e             trail_code;
    n = 0;
    if (r.chunk_start) vertex_count = '0;
    if (r.axis == AXIS_NONE) return;
    occ       = r.occupancy_bits & OCC_W'((33'd1 << ROW_CELLS) - 1);
    fwd_open  = occ & ~(occ >> 1);
    back_open = occ & ~(occ << 1);
    for (int c = 0; c < ROW_CELLS && c < OCC_W; c++) begin
      case (axis_e'(r.axis))
        AXIS_X: begin
          x = CELL_W'(c); y = r.outer_a; z = r.outer_b;
          lead_on = fwd_open[c];  lead_code  = FACE_POS_X;
          trail_on = back_open[c]; trail_code = FACE_NEG_X;
        end
        AXIS_Y: begin
          x = r.outer_a; y = CELL_W'(c); z = r.outer_b;
          lead_on = fwd_open[c];  lead_code  = FACE_POS_Y;
          trail_on = back_open[c]; trail_code = FACE_NEG_Y;
        end
        default: begin
          x = r.outer_a; y = r.outer_b; z = CELL_W'(c);
          lead_on = back_open[c]; lead_code  = FACE_NEG_Z;
          trail_on = fwd_open[c];  trail_code = FACE_POS_Z;
        end
      endcase
      if (lead_on && n < 32) begin
        faces[n] = build_face(lead_code, x, y, z);
        n++;
      end
      if (trail_on && n < 32) begin
        faces[n] = build_face(trail_code, x, y, z);
        n++;
      end
    end
    // Flag the final face of the row
    for (int i = 0; i < n; i++) begin
      if (i == n - 1) faces[i].last_face = 1'b1;
      pending_faces = {pending_faces, faces[i]};
    end
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatch_count_o++;
    end
  endtask

  // Compare accepted face words, then predict from accepted row words
  always @(posedge clk_i) begin
    face_t want;
    face_t got;
    if (!rst_ni) begin
      vertex_count = '0;
    end else begin
      if (face_mon_i.valid && face_mon_i.ready) begin
        got = face_mon_i.data;
        if (pending_faces.size() == 0) begin
          $error("face word with no face expected: code %0d cell (%0d,%0d,%0d)",
                 got.face_code, got.cell_x, got.cell_y, got.cell_z);
          mismatch_count_o++;
        end else begin
          want = pending_faces.pop_front();
          check_field("face_code", 32'(want.face_code), 32'(got.face_code));
          check_field("cell_x", 32'(want.cell_x), 32'(got.cell_x));
          check_field("cell_y", 32'(want.cell_y), 32'(got.cell_y));
          check_field("cell_z", 32'(want.cell_z), 32'(got.cell_z));
          check_field("corner_zero", 32'(want.corner_zero), 32'(got.corner_zero));
          check_field("corner_one", 32'(want.corner_one), 32'(got.corner_one));
          check_field("corner_two", 32'(want.corner_two), 32'(got.corner_two));
          check_field("corner_three", 32'(want.corner_three), 32'(got.corner_three));
          check_field("base_index", 32'(want.base_index), 32'(got.base_index));
          check_field("last_face", 32'(want.last_face), 32'(got.last_face));
          faces_checked_o++;
        end
      end
      if (row_mon_i.valid && row_mon_i.ready) cull_row(row_mon_i.data);
      faces_pending_o <= pending_faces.size();
    end
  end

endmodule

### sim/tb.sv
// Stimulus and verdict for the row face emitter; checking lives in face_checker.
module tb;
  import vrfe_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_ROWS = 449;
  localparam int unsigned QUIET_ROWS  = 80;
  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned IDLE_LIMIT  = 3000;
  localparam int unsigned TAIL_CYCLES = 40;

  logic clk_i;
  logic rst_ni;

  vrfe_row_if  row_if ();
  vrfe_face_if face_if ();

  int unsigned mismatch_count;
  int unsigned faces_pending;
  int unsigned faces_checked;
  int unsigned rows_sent;
  int unsigned directed_rows;
  int unsigned holds_asked;
  int unsigned sender_calm;
  bit          quiet_phase;

  voxel_row_face_emitter dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .row_i  (row_if),
    .face_o (face_if)
  );

  face_checker chk (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .row_mon_i        (row_if),
    .face_mon_i       (face_if),
    .mismatch_count_o (mismatch_count),
    .faces_pending_o  (faces_pending),
    .faces_checked_o  (faces_checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: end the run when no word moves for too long
  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (row_if.valid && row_if.ready) || (face_if.valid && face_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  // Receiver: random stall bursts, calm stretches, and long holds on request
  initial begin
    int unsigned stall_left;
    int unsigned calm_left;
    int unsigned hold_left;
    int unsigned holds_served;
    stall_left   = 0;
    calm_left    = 0;
    hold_left    = 0;
    holds_served = 0;
    face_if.ready <= 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (holds_served != holds_asked) begin
        holds_served++;
        hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        face_if.ready <= 1'b0;
      end else if (quiet_phase) begin
        face_if.ready <= 1'b1;
      end else if (stall_left != 0) begin
        stall_left--;
        face_if.ready <= 1'b0;
      end else if (calm_left != 0) begin
        calm_left--;
        face_if.ready <= 1'b1;
      end else if ($urandom_range(0, 24) == 0) begin
        calm_left = $urandom_range(20, 60);
        face_if.ready <= 1'b1;
      end else if ($urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 6) - 1;
        face_if.ready <= 1'b0;
      end else begin
        face_if.ready <= 1'b1;
      end
    end
  end

  function automatic row_t make_row(logic cs, axis_e ax, logic [CELL_W-1:0] a,
                                    logic [CELL_W-1:0] b, logic [OCC_W-1:0] occ);
    row_t r;
    r.chunk_start    = cs;
    r.axis           = ax;
    r.outer_a        = a;
    r.outer_b        = b;
    r.occupancy_bits = occ;
    return r;
  endfunction

  // Occupancy shapes: noise, sparse, dense, solid runs, checkerboards, extremes
  function automatic logic [OCC_W-1:0] random_occupancy();
    logic [OCC_W-1:0] v;
    int unsigned      lo;
    int unsigned      len;
    case ($urandom_range(0, 5))
      0: v = OCC_W'($urandom);
      1: v = OCC_W'($urandom) & OCC_W'($urandom) & OCC_W'($urandom);
      2: v = OCC_W'($urandom) | OCC_W'($urandom);
      3: begin
        lo  = $urandom_range(0, 15);
        len = $urandom_range(1, 16);
        v   = OCC_W'(((33'd1 << len) - 1) << lo);
      end
      4: v = ($urandom_range(0, 1) ? 16'h5555 : 16'hAAAA) ^ OCC_W'(1 << $urandom_range(0, 15));
      default: v = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    endcase
    return v;
  endfunction

  function automatic row_t random_row();
    axis_e ax;
    if ($urandom_range(0, 11) == 0) ax = AXIS_NONE;
    else ax = axis_e'($urandom_range(0, 2));
    return make_row($urandom_range(0, 15) == 0, ax, CELL_W'($urandom), CELL_W'($urandom),
                    random_occupancy());
  endfunction

  // Offer one row word, hold it until accepted, then maybe idle a burst
  task automatic send_row(input row_t r);
    int unsigned gap;
    row_if.valid <= 1'b1;
    row_if.data  <= r;
    @(posedge clk_i);
    while (!row_if.ready) @(posedge clk_i);
    rows_sent++;
    if (sender_calm != 0) begin
      sender_calm--;
    end else if (!quiet_phase && $urandom_range(0, 19) == 0) begin
      sender_calm = $urandom_range(20, 60);
    end else if (!quiet_phase && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 6);
      row_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stop offering and wait until every predicted face has arrived
  task automatic drain_faces();
    row_if.valid <= 1'b0;
    @(posedge clk_i);
    while (faces_pending != 0) @(posedge clk_i);
  endtask

  initial begin
    row_t r;
    rows_sent   = 0;
    holds_asked = 0;
    sender_calm = 0;
    quiet_phase = 1'b0;
    rst_ni      = 1'b0;
    row_if.valid <= 1'b0;
    row_if.data  <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: full rows, checkerboards (most faces), edges, empty and unused axis
    send_row(make_row(1'b1, AXIS_X, 4'd0, 4'd0, 16'hFFFF));
    send_row(make_row(1'b0, AXIS_Y, 4'd15, 4'd15, 16'hFFFF));
    send_row(make_row(1'b0, AXIS_Z, 4'd15, 4'd0, 16'hFFFF));
    send_row(make_row(1'b0, AXIS_X, 4'd15, 4'd15, 16'h5555));
    send_row(make_row(1'b0, AXIS_Y, 4'd0, 4'd15, 16'hAAAA));
    send_row(make_row(1'b0, AXIS_Z, 4'd7, 4'd9, 16'h5555));
    send_row(make_row(1'b0, AXIS_Z, 4'd0, 4'd0, 16'hAAAA));
    send_row(make_row(1'b0, AXIS_X, 4'd3, 4'd4, 16'h0000));
    send_row(make_row(1'b0, AXIS_NONE, 4'd1, 4'd2, 16'hFFFF));
    send_row(make_row(1'b1, AXIS_NONE, 4'd0, 4'd0, 16'h5555));
    send_row(make_row(1'b0, AXIS_X, 4'd0, 4'd0, 16'h0001));
    send_row(make_row(1'b0, AXIS_Y, 4'd0, 4'd0, 16'h8000));
    send_row(make_row(1'b0, AXIS_Z, 4'd15, 4'd15, 16'h8001));
    send_row(make_row(1'b0, AXIS_X, 4'd9, 4'd6, 16'h0FF0));
    send_row(make_row(1'b1, AXIS_Y, 4'd5, 4'd10, 16'h1234));
    send_row(make_row(1'b0, AXIS_Z, 4'd10, 4'd5, 16'hEDCB));
    send_row(make_row(1'b0, AXIS_NONE, 4'd15, 4'd15, 16'h0000));
    send_row(make_row(1'b1, AXIS_Z, 4'd0, 4'd15, 16'h0000));
    send_row(make_row(1'b0, AXIS_X, 4'd1, 4'd1, 16'h0003));
    directed_rows = rows_sent;
    drain_faces();

    // Hold the receiver off while dense rows keep coming, to fill the queue
    holds_asked <= holds_asked + 1;
    for (int i = 0; i < 12; i++) begin
      r = random_row();
      r.occupancy_bits = $urandom_range(0, 1) ? 16'h5555 : 16'hAAAA;
      send_row(r);
    end

    // Random rows, with no idling toward the end
    for (int i = 0; i < RANDOM_ROWS; i++) begin
      if (i == RANDOM_ROWS - QUIET_ROWS) quiet_phase <= 1'b1;
      send_row(random_row());
    end

    drain_faces();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Summary: %0d rows sent (%0d directed), %0d faces checked,", rows_sent,
             directed_rows, faces_checked);
    $display("  including a long output hold with the input stalled and a full drain.");
    if (mismatch_count == 0 && faces_pending == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

### filelist.f
+incdir+design
design/vrfe_pkg.sv
design/vrfe_row_if.sv
design/vrfe_face_if.sv
design/vrfe_front.sv
design/vrfe_queue.sv
design/vrfe_back.sv
design/voxel_row_face_emitter.sv
sim/face_checker.sv
sim/tb.sv
